@@ sv/fla_pkg.sv @@
package fla_pkg;

  localparam int PAGE_UNITS = 256;
  localparam int MAX_PAGES  = 16;
  localparam int UNIT_BYTES = 16;
  localparam int HEAP_UNITS = 1 + MAX_PAGES * PAGE_UNITS;

  localparam int ADDR_W = $clog2(HEAP_UNITS);
  localparam int SUM_W  = ADDR_W + 1;
  localparam int PG_W   = $clog2(MAX_PAGES + 1);

  // Step bounds of the allocation walk and of the release walk.
  localparam int ALLOC_BUDGET = (MAX_PAGES + 2) * (HEAP_UNITS + 2);
  localparam int STEP_W       = $clog2(ALLOC_BUDGET + 1);
  localparam int REL_LIMIT    = HEAP_UNITS + 1;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_PAGES  = 2'd1;
  localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;

  typedef struct packed {
    logic        command;
    logic [15:0] byte_count;
    logic [12:0] block_address;
  } req_t;

  typedef struct packed {
    logic [12:0] payload_address;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] nxt;
    logic [ADDR_W-1:0] len;
  } hdr_t;

  typedef struct packed {
    logic              en;
    logic [SUM_W-1:0]  addr;
    hdr_t              data;
  } hdr_wr_t;

  function automatic logic [ADDR_W-1:0] sat_len(logic [SUM_W-1:0] v);
    if (v > SUM_W'(HEAP_UNITS)) begin
      return ADDR_W'(HEAP_UNITS);
    end
    return v[ADDR_W-1:0];
  endfunction

endpackage

@@ sv/fla_hdr_mem.sv @@
module fla_hdr_mem
  import fla_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [SUM_W-1:0] rd_addr,
  output hdr_t             rd_data,
  input  hdr_wr_t          wr,
  output logic             busy
);

  hdr_t              mem [HEAP_UNITS];
  hdr_t              rd_q;
  logic              rd_ok;
  logic              clearing;
  logic [ADDR_W-1:0] clr_idx;

  // After reset every header is swept to zero, one entry per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == ADDR_W'(HEAP_UNITS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (wr.en && wr.addr < SUM_W'(HEAP_UNITS)) begin
      mem[wr.addr[ADDR_W-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok <= rd_addr < SUM_W'(HEAP_UNITS);
    rd_q  <= mem[rd_addr[ADDR_W-1:0]];
  end

  // Headers outside the store read as zero.
  assign rd_data = rd_ok ? rd_q : '0;
  assign busy    = clearing;

endmodule

@@ sv/free_list_allocator.sv @@
// Next-fit free-list allocator over a header memory of HEAP_UNITS 16-byte units.
// Allocations and releases walk the circular free list through a one-port-read
// header memory with a registered read: the allocation walk visits one node per
// cycle, the release walk one node per cycle, then S_R_RD_H, S_R_RD_N, S_R_WR_CUR
// to merge and finish, and granting a page adds a full release. A too-large request
// goes straight to S_DONE; an allocation that fits at the first node visited
// passes S_A_ROVER, S_A_PREV, S_A_EVAL and, if it carves, S_A_CARVE; beyond that
// the time is set by the length of the free list between the rover and the fit.
// After reset the header memory is cleared one entry per cycle while no request is
// accepted; page_limit may be written at any time the block is idle.
module free_list_allocator
  import fla_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp,
  input  logic       page_limit_we,
  input  logic [4:0] page_limit_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_REL_CHK, S_A_ROVER, S_A_PREV, S_A_EVAL, S_A_CARVE, S_A_GRANT,
    S_R_START, S_R_WALK, S_R_RD_H, S_R_RD_N, S_R_WR_CUR, S_DONE
  } state_t;

  state_t            state;
  logic [4:0]        page_limit;
  logic [PG_W-1:0]   pages_granted;
  logic [ADDR_W-1:0] rover;
  logic [ADDR_W-1:0] h;
  logic [ADDR_W-1:0] cur;
  logic [SUM_W-1:0]  cur2;
  logic [ADDR_W-1:0] prev;
  logic [ADDR_W-1:0] prev_len;
  logic [ADDR_W-1:0] need;
  logic [STEP_W-1:0] steps;
  logic [ADDR_W-1:0] rsteps;
  logic [ADDR_W-1:0] scur;
  logic [ADDR_W-1:0] n;
  logic [ADDR_W-1:0] hl;
  logic [ADDR_W-1:0] hnx;
  logic              from_alloc;
  rsp_t              res;

  hdr_t              d;
  hdr_wr_t           wr;
  logic [SUM_W-1:0]  rd_addr;
  logic              mem_busy;

  logic              accept;
  logic [SUM_W-1:0]  page_end;
  logic [PG_W-1:0]   cap;
  logic [ADDR_W-1:0] need_c;
  logic [ADDR_W-1:0] req_h;
  logic              in_gap;
  logic              wrap_brk;
  logic              merge_hi;
  logic [ADDR_W-1:0] hl_c;
  logic [ADDR_W-1:0] hnx_c;
  logic [ADDR_W-1:0] scur_e;
  logic              merge_lo;

  fla_hdr_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (d),
    .wr      (wr),
    .busy    (mem_busy)
  );

  assign req_stall = (state != S_IDLE) || mem_busy;
  assign accept    = req_valid && !req_stall;

  assign page_end = SUM_W'(pages_granted) * SUM_W'(PAGE_UNITS) + 1'b1;
  assign cap      = (page_limit > 5'(MAX_PAGES)) ? PG_W'(MAX_PAGES) : PG_W'(page_limit);
  assign need_c   = ADDR_W'((17'(req.byte_count) + 17'(UNIT_BYTES - 1)) / UNIT_BYTES + 1);
  assign req_h    = req.block_address - 1'b1;

  assign in_gap   = (cur < h) && (h < d.nxt);
  assign wrap_brk = (cur >= d.nxt) && ((cur < h) || (h < d.nxt));

  // Merge of the released block with its upper neighbor; hl holds its old size here.
  assign merge_hi = (SUM_W'(h) + SUM_W'(hl)) == SUM_W'(n);
  assign hl_c     = merge_hi ? sat_len(SUM_W'(hl) + SUM_W'(d.len)) : hl;
  assign hnx_c    = merge_hi ? d.nxt : n;

  // If the walk stopped on the block itself, its size is the one just written.
  assign scur_e   = (cur == h) ? hl : scur;
  assign merge_lo = (SUM_W'(cur) + SUM_W'(scur_e)) == SUM_W'(h);

  always_comb begin
    rd_addr = SUM_W'(rover);
    wr      = '0;
    unique case (state)
      S_IDLE:     rd_addr = SUM_W'(req_h);
      S_A_ROVER,
      S_R_START:  rd_addr = SUM_W'(rover);
      S_A_PREV:   rd_addr = SUM_W'(d.nxt);
      S_A_EVAL: begin
        rd_addr = SUM_W'(d.nxt);
        if (steps < STEP_W'(ALLOC_BUDGET) && d.len >= need) begin
          wr.en = 1'b1;
          if (d.len == need) begin
            wr.addr = SUM_W'(prev);
            wr.data = '{nxt: d.nxt, len: prev_len};
          end else begin
            wr.addr = SUM_W'(cur);
            wr.data = '{nxt: d.nxt, len: d.len - need};
            rd_addr = SUM_W'(cur) + SUM_W'(d.len - need);
          end
        end else if (cur == rover) begin
          rd_addr = page_end;
        end
      end
      S_A_CARVE: begin
        wr.en   = 1'b1;
        wr.addr = cur2;
        wr.data = '{nxt: d.nxt, len: need};
      end
      S_A_GRANT: begin
        wr.en   = 1'b1;
        wr.addr = SUM_W'(h);
        wr.data = '{nxt: d.nxt, len: ADDR_W'(PAGE_UNITS)};
      end
      S_R_WALK:   rd_addr = (in_gap || wrap_brk) ? SUM_W'(h) : SUM_W'(d.nxt);
      S_R_RD_H:   rd_addr = SUM_W'(n);
      S_R_RD_N: begin
        wr.en   = 1'b1;
        wr.addr = SUM_W'(h);
        wr.data = '{nxt: hnx_c, len: hl_c};
      end
      S_R_WR_CUR: begin
        wr.en   = 1'b1;
        wr.addr = SUM_W'(cur);
        if (merge_lo) begin
          wr.data = '{nxt: hnx, len: sat_len(SUM_W'(scur_e) + SUM_W'(hl))};
        end else begin
          wr.data = '{nxt: h, len: scur_e};
        end
      end
      S_REL_CHK,
      S_DONE:     rd_addr = SUM_W'(rover);
      default:    rd_addr = SUM_W'(rover);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      page_limit    <= 5'd16;
      pages_granted <= '0;
      rover         <= '0;
      rsp_valid     <= 1'b0;
      from_alloc    <= 1'b0;
    end else begin
      if (page_limit_we) begin
        page_limit <= page_limit_wdata;
      end
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.command == CMD_ALLOC) begin
              need  <= need_c;
              steps <= '0;
              if (need_c > ADDR_W'(PAGE_UNITS)) begin
                res   <= '{payload_address: '0, status: STATUS_TOO_LARGE};
                state <= S_DONE;
              end else begin
                res   <= '{payload_address: '0, status: STATUS_OK};
                state <= S_A_ROVER;
              end
            end else begin
              res <= '{payload_address: '0, status: STATUS_OK};
              h   <= req_h;
              if (req.block_address == '0 || req_h == '0 ||
                  SUM_W'(req_h) >= page_end) begin
                state <= S_DONE;
              end else begin
                state <= S_REL_CHK;
              end
            end
          end
        end
        S_REL_CHK: begin
          if (d.len == '0 || SUM_W'(h) + SUM_W'(d.len) > page_end) begin
            state <= S_DONE;
          end else begin
            from_alloc <= 1'b0;
            state      <= S_R_START;
          end
        end
        S_A_ROVER: state <= S_A_PREV;
        S_A_PREV: begin
          prev     <= rover;
          prev_len <= d.len;
          cur      <= d.nxt;
          state    <= S_A_EVAL;
        end
        S_A_EVAL: begin
          if (steps >= STEP_W'(ALLOC_BUDGET)) begin
            res.status <= STATUS_NO_PAGES;
            state      <= S_DONE;
          end else if (d.len >= need) begin
            if (d.len == need) begin
              rover                <= prev;
              res.payload_address  <= cur + 1'b1;
              state                <= S_DONE;
            end else begin
              cur2  <= SUM_W'(cur) + SUM_W'(d.len - need);
              state <= S_A_CARVE;
            end
          end else if (cur == rover) begin
            if (pages_granted >= cap) begin
              res.status <= STATUS_NO_PAGES;
              state      <= S_DONE;
            end else begin
              h     <= page_end[ADDR_W-1:0];
              state <= S_A_GRANT;
            end
          end else begin
            prev     <= cur;
            prev_len <= d.len;
            cur      <= d.nxt;
            steps    <= steps + 1'b1;
          end
        end
        S_A_CARVE: begin
          rover               <= prev;
          res.payload_address <= cur2[ADDR_W-1:0] + 1'b1;
          state               <= S_DONE;
        end
        S_A_GRANT: begin
          pages_granted <= pages_granted + 1'b1;
          from_alloc    <= 1'b1;
          state         <= S_R_START;
        end
        S_R_START: begin
          cur    <= rover;
          rsteps <= '0;
          state  <= S_R_WALK;
        end
        S_R_WALK: begin
          if (in_gap || wrap_brk) begin
            n     <= d.nxt;
            scur  <= d.len;
            state <= S_R_RD_H;
          end else if (rsteps >= ADDR_W'(REL_LIMIT)) begin
            // Walk ran out of steps: the release is dropped.
            if (from_alloc) begin
              steps <= steps + 1'b1;
              state <= S_A_ROVER;
            end else begin
              state <= S_DONE;
            end
          end else begin
            cur    <= d.nxt;
            rsteps <= rsteps + 1'b1;
          end
        end
        S_R_RD_H: begin
          hl    <= d.len;
          state <= S_R_RD_N;
        end
        S_R_RD_N: begin
          hl    <= hl_c;
          hnx   <= hnx_c;
          state <= S_R_WR_CUR;
        end
        S_R_WR_CUR: begin
          rover <= cur;
          if (from_alloc) begin
            steps <= steps + 1'b1;
            state <= S_A_ROVER;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    mem_busy |-> req_stall)
    else $error("request accepted during header clear");

  a_failed_has_no_address: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != STATUS_OK |-> rsp.payload_address == '0)
    else $error("failed allocation returned an address");

  a_pages_bounded: assert property (@(posedge clk) disable iff (rst)
    pages_granted <= PG_W'(MAX_PAGES))
    else $error("more pages granted than exist");

  a_grant_counts_one: assert property (@(posedge clk) disable iff (rst)
    state == S_A_GRANT |=> pages_granted == $past(pages_granted) + 1'b1)
    else $error("page grant did not advance the page count");

endmodule
